/* src/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] PadChar = 7'd61;  // '='

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD = 2'd2
  } phase_t;

  // One accepted byte, broken into the characters it causes.
  typedef struct packed {
    logic [3:0][5:0] sextet;  // six-bit groups, slot 0 first
    logic [3:0]      pad;     // slot is a '=' character
    logic [1:0]      last;    // index of the final slot in use
    logic            fin;     // byte closes the message
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};        // 'a' - 26
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;         // '0' - 52
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

/* src/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Tracks the position in the three-byte group and turns each byte into a job.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  input  logic            q_full,
  output logic            q_write,
  output b64e_pkg::job_t  q_job
);
  import b64e_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] leftover, leftover_next;
  job_t       job;

  assign q_write = push && !q_full;
  assign q_job   = job;

  always_comb begin
    job           = '0;
    leftover_next = leftover;
    phase_next    = phase;
    unique case (phase)
      PH_SECOND: begin
        job.sextet[0] = {leftover[1:0], data_byte[7:4]};
        job.last      = 2'd0;
        leftover_next = data_byte[3:0];
        phase_next    = PH_THIRD;
      end
      PH_THIRD: begin
        job.sextet[0] = {leftover[3:0], data_byte[7:6]};
        job.sextet[1] = data_byte[5:0];
        job.last      = 2'd1;
        leftover_next = 4'd0;
        phase_next    = PH_START;
      end
      default: begin
        job.sextet[0] = data_byte[7:2];
        job.last      = 2'd0;
        leftover_next = {2'b00, data_byte[1:0]};
        phase_next    = PH_SECOND;
      end
    endcase

    if (final_byte) begin
      job.fin = 1'b1;
      if (phase_next == PH_SECOND) begin
        job.sextet[1] = {leftover_next[1:0], 4'd0};
        job.pad       = 4'b1100;
        job.last      = 2'd3;
      end else if (phase_next == PH_THIRD) begin
        job.sextet[1] = {leftover_next[3:0], 2'd0};
        job.pad       = 4'b0100;
        job.last      = 2'd2;
      end
      leftover_next = 4'd0;
      phase_next    = PH_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      leftover <= 4'd0;
    end else if (q_write) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

  // Leftover bits beyond the two of the second position must be clear there.
  a_left_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SECOND) |-> (leftover[3:2] == 2'b00))
    else $error("leftover bits set beyond group position");

endmodule

/* src/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            write,
  input  b64e_pkg::job_t  wr_job,
  input  logic            read,
  output b64e_pkg::job_t  rd_job,
  output logic            full,
  output logic            valid
);
  import b64e_pkg::*;

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full   = (count == QCntW'(QDepth));
  assign valid  = (count != '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (write) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (write) wr_ptr <= wr_ptr + 1'b1;
      if (read)  rd_ptr <= rd_ptr + 1'b1;
      if (write && !read)      count <= count + 1'b1;
      else if (read && !write) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("job queue overflow");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    read |-> valid)
    else $error("job queue read while empty");

endmodule

/* src/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Walks the slots of the head job into the output register, one character per
// cycle while a job waits and the register is empty or being popped.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  b64e_pkg::job_t  q_job,
  output logic            q_read,
  input  logic            pop,
  output logic            empty,
  output logic [6:0]      code_char,
  output logic            run_end,
  output logic            message_end
);
  import b64e_pkg::*;

  logic [1:0] slot;
  logic       out_valid;
  logic       load;
  logic       at_last;
  logic [6:0] char_next;

  assign empty   = !out_valid;
  assign load    = q_valid && (!out_valid || pop);
  assign at_last = (slot == q_job.last);
  assign q_read  = load && at_last;
  assign char_next = q_job.pad[slot] ? PadChar : b64_char(q_job.sextet[slot]);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= at_last ? 2'd0 : slot + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_char   <= char_next;
      run_end     <= at_last;
      message_end <= at_last && q_job.fin;
    end
  end

  a_end_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_end) |-> run_end)
    else $error("message end without run end");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (slot <= q_job.last))
    else $error("slot index past last slot of job");

endmodule

/* src/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: present data_byte with final_byte and raise push; a
//   transfer happens on a rising edge with push high and full low. Mark the
//   last byte of each message with final_byte; the next byte starts a new one.
//   Output queue side: while empty is low, code_char holds the oldest ASCII
//   character; run_end flags the last character of its byte and message_end
//   the last character of the message. A transfer happens on pop && !empty.
// Path: a byte's job is written into the job queue; its first character is
//   then loaded into the output register once that register is free.
// Throughput: one character per cycle while pop stays high and jobs wait, set
//   by the single output register fed by the character walker in the back end.
//   Three bytes give four characters; a final byte gives up to four (flush character plus '=' pads).
// Reset (rst, synchronous, active high) empties the job queue and output
//   register and returns the encoder to the start of a three-byte group.
// Stall: when pop stays low the output register holds; the front keeps
//   taking bytes until the four-entry job queue fills, then raises full.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] code_char,
  output logic       run_end,
  output logic       message_end
);
  import b64e_pkg::*;

  // front to queue
  logic q_write;
  job_t wr_job;
  // queue to back
  logic q_read;
  logic q_valid;
  job_t rd_job;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (full),
    .q_write    (q_write),
    .q_job      (wr_job)
  );

  // Job queue decouples byte intake from character output.
  b64e_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .write  (q_write),
    .wr_job (wr_job),
    .read   (q_read),
    .rd_job (rd_job),
    .full   (full),
    .valid  (q_valid)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (rd_job),
    .q_read      (q_read),
    .pop         (pop),
    .empty       (empty),
    .code_char   (code_char),
    .run_end     (run_end),
    .message_end (message_end)
  );

endmodule

/* test/base64_checker.sv */
// ----------------------------------------------------------------------------
// base64_checker
// Watches both queue sides of the base64 encoder, predicts the character
// stream of every accepted byte and compares each popped character with it.
// ----------------------------------------------------------------------------
module base64_checker
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] code_char,
  input  logic       run_end,
  input  logic       message_end,
  output int         mismatches,
  output int         awaiting,
  output int         bytes_taken,
  output int         chars_checked,
  output int         messages_done
);

  typedef struct packed {
    logic [6:0] code;
    logic       run_end;
    logic       message_end;
  } b64_char_t;

  // Index 0 is the leftmost character of the literal.
  localparam logic [0:63][7:0] CharMap =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64_char_t  char_queue[$];
  b64_char_t  want;
  logic [3:0] carry;
  phase_t     phase;
  int         fail_count;
  int         byte_count;
  int         char_count;
  int         msg_count;

  initial begin
    carry      = '0;
    phase      = PH_START;
    fail_count = 0;
    byte_count = 0;
    char_count = 0;
    msg_count  = 0;
  end

  // Characters caused by one byte, appended to the queue.
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [6:0] codes[4];
    int         n;
    n = 0;
    case (phase)
      PH_SECOND: begin
        codes[0] = CharMap[{carry[1:0], b[7:4]}][6:0];
        n        = 1;
        carry    = b[3:0];
        phase    = PH_THIRD;
      end
      PH_THIRD: begin
        codes[0] = CharMap[{carry, b[7:6]}][6:0];
        codes[1] = CharMap[b[5:0]][6:0];
        n        = 2;
        carry    = '0;
        phase    = PH_START;
      end
      default: begin  // start of group; the unused code behaves the same
        codes[0] = CharMap[b[7:2]][6:0];
        n        = 1;
        carry    = {2'b00, b[1:0]};
        phase    = PH_SECOND;
      end
    endcase
    if (fin) begin
      // flush leftover bits, zero-filled, then pad to four characters
      if (phase == PH_SECOND) begin
        codes[1] = CharMap[{carry[1:0], 4'b0000}][6:0];
        codes[2] = PadChar;
        codes[3] = PadChar;
        n        = 4;
      end else if (phase == PH_THIRD) begin
        codes[1] = CharMap[{carry, 2'b00}][6:0];
        codes[2] = PadChar;
        n        = 3;
      end
      carry = '0;
      phase = PH_START;
    end
    for (int i = 0; i < n; i++) begin
      char_queue.push_back('{code: codes[i], run_end: (i == n - 1),
                             message_end: fin && (i == n - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      char_queue.delete();
      carry = '0;
      phase = PH_START;
    end else begin
      // output side first: a character can never belong to a byte that
      // transfers at the same edge
      if (pop && !empty) begin
        if (char_queue.size() == 0) begin
          $display("%0t: unexpected character, expected none, got %0d (run_end %0b msg_end %0b)",
                   $time, code_char, run_end, message_end);
          fail_count++;
        end else begin
          want = char_queue.pop_front();
          if (code_char !== want.code) begin
            $display("%0t: code_char expected %0d, got %0d", $time, want.code, code_char);
            fail_count++;
          end
          if (run_end !== want.run_end) begin
            $display("%0t: run_end expected %0b, got %0b", $time, want.run_end, run_end);
            fail_count++;
          end
          if (message_end !== want.message_end) begin
            $display("%0t: message_end expected %0b, got %0b",
                     $time, want.message_end, message_end);
            fail_count++;
          end
          char_count++;
        end
      end
      if (push && !full) begin
        encode_byte(data_byte, final_byte);
        byte_count++;
        if (final_byte) msg_count++;
      end
    end
    mismatches    <= fail_count;
    awaiting      <= char_queue.size();
    bytes_taken   <= byte_count;
    chars_checked <= char_count;
    messages_done <= msg_count;
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives byte messages into the base64 stream encoder with random gaps and
// output stalls; a checker beside the encoder predicts every character.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 7;
  localparam int RandomBytes = 88;
  localparam int MaxWait     = 6;
  localparam int DrainCycles = 8;       // quiet cycles after the last predicted character
  localparam int CycleLimit  = 100000;  // watchdog limit for the whole run

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       push       = 1'b0;
  logic [7:0] data_byte  = 8'h00;
  logic       final_byte = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [6:0] code_char;
  logic       run_end;
  logic       message_end;

  int mismatches;
  int awaiting;
  int bytes_taken;
  int chars_checked;
  int messages_done;
  int cycle_count = 0;

  // When set, both sides run back to back with no idle cycles.
  bit calm = 1'b0;

  base64_stream_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .empty       (empty),
    .pop         (pop),
    .code_char   (code_char),
    .run_end     (run_end),
    .message_end (message_end)
  );

  base64_checker chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .final_byte    (final_byte),
    .empty         (empty),
    .pop           (pop),
    .code_char     (code_char),
    .run_end       (run_end),
    .message_end   (message_end),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .bytes_taken   (bytes_taken),
    .chars_checked (chars_checked),
    .messages_done (messages_done)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  // One byte transfer. Push is left high afterwards so that a zero gap
  // keeps the input side streaming with a single assignment per edge.
  // full is read right after the edge, i.e. the value the encoder saw.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(MaxWait, 0);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (full);
  endtask

  initial begin
    int         sent;
    int         len;
    logic [7:0] b;
    sent = 0;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Output side: a random stall before each character transfer.
    fork
      forever begin
        int stall;
        stall = calm ? 0 : $urandom_range(MaxWait, 0);
        if (stall != 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        pop <= 1'b1;
        do @(posedge clk); while (empty);
      end
    join_none

    // Directed: one-byte messages (flush plus two pads) at both extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two-byte messages: flush plus one pad
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b1);
    // full groups, no padding; gives the '+' and '/' characters
    send_byte(8'hFB, 1'b0); send_byte(8'hEF, 1'b0); send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
    // group boundary crossed, message ends on the second group's first byte
    calm = 1'b1;
    send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b0); send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b1);
    calm = 1'b0;
    // six bytes, two complete groups; messages back to back show the
    // state returns to the start of a group after the final byte
    send_byte(8'h14, 1'b0); send_byte(8'hFB, 1'b0); send_byte(8'h9C, 1'b0);
    send_byte(8'h03, 1'b0); send_byte(8'hD9, 1'b0); send_byte(8'h7E, 1'b1);

    // Random messages, mostly short, now and then long; about one in four
    // runs with no idling on either side.
    while (sent < RandomBytes) begin
      len  = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      calm = ($urandom_range(3, 0) == 0);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7, 0))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(255, 0));
        endcase
        send_byte(b, i == len - 1);
        sent++;
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    // Drain: wait for every predicted character, then a few quiet cycles
    // to catch anything extra.
    do @(posedge clk); while (awaiting != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Encoded %0d messages from %0d bytes; %0d characters compared.",
             messages_done, bytes_taken, chars_checked);
    $display("Messages ended in every group position, under random gaps and stalls.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
